// ===== rtl/core/skf_pkg.sv =====
`default_nettype none
package skf_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W = 32;
	localparam int CFG_IDX_W = 2;
	// innovation and variance operands of the serial multipliers
	localparam int MCAND_W = DATA_W + 1;
	localparam int ACC_W = DATA_W + 3;

	localparam logic [CFG_IDX_W-1:0] REG_INIT_ESTIMATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_VARIANCE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 2'd3;

	localparam logic [DATA_W-1:0] ESTIMATE_RESET = 32'd0;
	localparam logic [DATA_W-1:0] VARIANCE_RESET = 32'd65536;
	localparam logic [DATA_W-1:0] PROCESS_NOISE_RESET = 32'd0;
	localparam logic [DATA_W-1:0] MEAS_NOISE_RESET = 32'd65536;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEN,
		ST_NUM,
		ST_DIV,
		ST_GAIN,
		ST_MUL,
		ST_ROUND,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/core/skf_serial_div.sv =====
`default_nettype none
module skf_serial_div
	import skf_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [FRAC_BITS+DATA_W:0]     num,
	input  wire logic [DATA_W:0]               den,
	output logic                               done,
	output logic [FRAC_BITS:0]                 quot
);

	localparam int CNT_W = $clog2(FRAC_BITS + 2);

	logic [DATA_W:0]      rem_q;
	logic [FRAC_BITS:0]   nlow_q;
	logic [FRAC_BITS:0]   quot_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DATA_W+1:0]    shifted;
	logic [DATA_W+2:0]    diff;
	logic                 ge;

	// one quotient bit per cycle, restoring
	assign shifted = {rem_q, nlow_q[FRAC_BITS]};
	assign diff = {1'b0, shifted} - {2'b00, den};
	assign ge = !diff[DATA_W+2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(FRAC_BITS + 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// quotient fits in FRAC_BITS+1 bits, so the top part is already below den
			rem_q <= {1'b0, num[FRAC_BITS+DATA_W:FRAC_BITS+1]};
			nlow_q <= num[FRAC_BITS:0];
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DATA_W:0] : shifted[DATA_W:0];
			nlow_q <= {nlow_q[FRAC_BITS-1:0], 1'b0};
			quot_q <= {quot_q[FRAC_BITS-1:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

// ===== rtl/core/skf_serial_mul.sv =====
`default_nettype none
module skf_serial_mul
	import skf_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic signed [MCAND_W-1:0]  mcand,
	input  wire logic [FRAC_BITS:0]         mplier,
	output logic                            done,
	output logic signed [ACC_W-1:0]         prod_hi,
	output logic [FRAC_BITS:0]              prod_lo
);

	localparam int CNT_W = $clog2(FRAC_BITS + 2);

	logic signed [MCAND_W-1:0] mcand_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic [FRAC_BITS:0]        mreg_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;

	logic signed [ACC_W-1:0]   addend;
	logic signed [ACC_W-1:0]   sum;

	// shift-add, one multiplier bit per cycle; low product bits shift into mreg
	assign addend = mreg_q[0] ? {{(ACC_W-MCAND_W){mcand_q[MCAND_W-1]}}, mcand_q} : '0;
	assign sum = acc_q + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(FRAC_BITS + 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			acc_q <= '0;
			mreg_q <= mplier;
		end else if (busy_q) begin
			acc_q <= {sum[ACC_W-1], sum[ACC_W-1:1]};
			mreg_q <= {sum[0], mreg_q[FRAC_BITS:1]};
		end
	end

	assign done = done_q;
	assign prod_hi = acc_q;
	assign prod_lo = mreg_q;

endmodule
`default_nettype wire

// ===== rtl/core/scalar_kalman_filter_top.sv =====
// scalar kalman filter, one dimension
// input channel: in_valid/in_ready with one measurement word, signed fixed point
// output channel: out_valid/out_ready with filtered_estimate and kalman_gain
// config port: cfg_wen/cfg_index/cfg_data; the user must write it only while the
//   filter is idle, which the block does not enforce; index 0 loads the estimate,
//   1 loads the error variance, 2 sets Q, 3 sets R
// one measurement is worked at a time: in_ready is high only in idle
// the path from accept to out_valid runs through the radix-2 gain divider, then
//   the shift-add multipliers, each working through FRAC_BITS+1 bits serially and
//   raising a done flag when finished; the two multipliers run side by side
// the next word is taken in the idle state, after the previous result has been
//   loaded into the output register
// the result sits in an output register, so the next measurement is accepted
//   while the previous result still waits; if it still waits when the next
//   result is ready, the filter holds in its last step until out_ready
// reset: estimate 0, variance 1.0, Q 0, R 1.0, no result pending
`default_nettype none
module scalar_kalman_filter_top
	import skf_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [DATA_W-1:0]          cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [DATA_W-1:0]   measurement,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [DATA_W-1:0]        filtered_estimate,
	output logic [FRAC_BITS:0]              kalman_gain
);

	localparam int NUM_W = FRAC_BITS + DATA_W + 1;
	localparam int ADJ_W = ACC_W + 1;
	localparam int NX_W = ADJ_W + 1;
	localparam logic [FRAC_BITS:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	state_t state_q, state_d;

	logic signed [DATA_W-1:0] estimate_q;
	logic [DATA_W-1:0]        variance_q;
	logic [DATA_W-1:0]        pnoise_q;
	logic [DATA_W-1:0]        mnoise_q;

	logic signed [DATA_W-1:0]  z_q;
	logic [DATA_W-1:0]         pp_q;
	logic [DATA_W:0]           den_q;
	logic signed [MCAND_W-1:0] innov_q;
	logic [FRAC_BITS:0]        gain_q;
	logic signed [ADJ_W-1:0]   adj_q;
	logic                      out_valid_q;
	logic signed [DATA_W-1:0]  out_est_q;
	logic [FRAC_BITS:0]        out_gain_q;

	logic            accept;
	logic            load_den;
	logic            load_gain;
	logic            load_round;
	logic            load_out;
	logic            div_start;
	logic            div_done;
	logic            mul_start;
	logic            mul_done;
	logic            mul2_done;

	logic [DATA_W:0]          pp_sum;
	logic [NUM_W-1:0]         num;
	logic [FRAC_BITS:0]       div_quot;
	logic [FRAC_BITS:0]       gain_d;
	logic [FRAC_BITS:0]       one_minus_gain;

	logic signed [ACC_W-1:0]  p1_hi;
	logic [FRAC_BITS:0]       p1_lo;
	logic signed [ACC_W-1:0]  p2_hi;
	logic [FRAC_BITS:0]       p2_lo;
	logic signed [ADJ_W-1:0]  adj_d;
	logic [ADJ_W-1:0]         np_d;
	logic signed [NX_W-1:0]   nx_sum;
	logic signed [DATA_W-1:0] nx_sat;

	// prior variance sum, saturated when registered into pp_q
	assign pp_sum = {1'b0, variance_q} + {1'b0, pnoise_q};

	// numerator pp*2^F + den/2
	assign num = {1'b0, pp_q, {FRAC_BITS{1'b0}}} + {{(FRAC_BITS+1){1'b0}}, den_q[DATA_W:1]};

	assign gain_d = (den_q == '0) ? '0 : ((div_quot > GAIN_ONE) ? GAIN_ONE : div_quot);
	assign one_minus_gain = GAIN_ONE - gain_d;

	skf_serial_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// gain times innovation
	skf_serial_mul #(
		.FRAC_BITS(FRAC_BITS)
	) u_mul_est (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (innov_q),
		.mplier  (gain_d),
		.done    (mul_done),
		.prod_hi (p1_hi),
		.prod_lo (p1_lo)
	);

	// one minus gain times prior variance
	skf_serial_mul #(
		.FRAC_BITS(FRAC_BITS)
	) u_mul_var (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   ($signed({1'b0, pp_q})),
		.mplier  (one_minus_gain),
		.done    (mul2_done),
		.prod_hi (p2_hi),
		.prod_lo (p2_lo)
	);

	// round half up: shift by F and add the bit just below
	assign adj_d = $signed({p1_hi, p1_lo[FRAC_BITS]})
		+ $signed({{(ADJ_W-1){1'b0}}, p1_lo[FRAC_BITS-1]});
	assign np_d = {p2_hi, p2_lo[FRAC_BITS]} + {{(ADJ_W-1){1'b0}}, p2_lo[FRAC_BITS-1]};

	assign nx_sum = $signed({{(NX_W-DATA_W){estimate_q[DATA_W-1]}}, estimate_q})
		+ $signed({adj_q[ADJ_W-1], adj_q});

	always_comb begin
		if (nx_sum[NX_W-1:DATA_W-1] == '0 || nx_sum[NX_W-1:DATA_W-1] == '1) begin
			nx_sat = nx_sum[DATA_W-1:0];
		end else if (nx_sum[NX_W-1]) begin
			nx_sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			nx_sat = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		load_den = 1'b0;
		load_gain = 1'b0;
		load_round = 1'b0;
		load_out = 1'b0;
		div_start = 1'b0;
		mul_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_DEN;
				end
			end
			ST_DEN: begin
				load_den = 1'b1;
				state_d = ST_NUM;
			end
			ST_NUM: begin
				div_start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_GAIN;
				end
			end
			ST_GAIN: begin
				load_gain = 1'b1;
				mul_start = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				if (mul_done && mul2_done) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				load_round = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	// state and config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			estimate_q <= ESTIMATE_RESET;
			variance_q <= VARIANCE_RESET;
			pnoise_q <= PROCESS_NOISE_RESET;
			mnoise_q <= MEAS_NOISE_RESET;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_INIT_ESTIMATE: estimate_q <= cfg_data;
					REG_INIT_VARIANCE: variance_q <= cfg_data;
					REG_PROCESS_NOISE: pnoise_q <= cfg_data;
					REG_MEAS_NOISE: mnoise_q <= cfg_data;
					default: ;
				endcase
			end
			if (load_round) begin
				variance_q <= (np_d[ADJ_W-1:DATA_W] != '0) ? '1 : np_d[DATA_W-1:0];
			end
			if (load_out) begin
				estimate_q <= nx_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			z_q <= measurement;
			pp_q <= pp_sum[DATA_W] ? '1 : pp_sum[DATA_W-1:0];
		end
		if (load_den) begin
			den_q <= {1'b0, pp_q} + {1'b0, mnoise_q};
			innov_q <= $signed({z_q[DATA_W-1], z_q}) - $signed({estimate_q[DATA_W-1], estimate_q});
		end
		if (load_gain) begin
			gain_q <= gain_d;
		end
		if (load_round) begin
			adj_q <= adj_d;
		end
		if (load_out) begin
			out_est_q <= nx_sat;
			out_gain_q <= gain_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered_estimate = out_est_q;
	assign kalman_gain = out_gain_q;

endmodule
`default_nettype wire

// ===== bench/scalar_kalman_filter_top_tb.sv =====
module scalar_kalman_filter_top_tb
	import skf_pkg::*;
();

	localparam int F = FRAC_BITS_DEF;
	localparam int LATENCY = 2 * F + 9;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int ITEMS_PER_PHASE = 480;
	localparam int RECONFIG_EVERY = 40;
	localparam int NUM_DIRECTED = 26;
	localparam logic [63:0] GAIN_ONE = 64'd1 << F;
	localparam logic [63:0] HALF_LSB = 64'd1 << (F - 1);
	localparam logic [63:0] U32_MAX = 64'hFFFF_FFFF;

	typedef struct packed {
		logic [DATA_W-1:0] est;
		logic [F:0] gain;
	} filter_result_t;

	typedef struct packed {
		logic is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [DATA_W-1:0] data;
		logic typed;
		logic [DATA_W-1:0] est;
		logic [F:0] gain;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [DATA_W-1:0] measurement = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DATA_W-1:0] filtered_estimate;
	logic [F:0] kalman_gain;

	// filter model state and settings
	logic signed [DATA_W-1:0] est_model = ESTIMATE_RESET;
	logic [DATA_W-1:0] var_model = VARIANCE_RESET;
	logic [DATA_W-1:0] q_model = PROCESS_NOISE_RESET;
	logic [DATA_W-1:0] r_model = MEAS_NOISE_RESET;

	filter_result_t pending_results[$];
	filter_result_t predicted;
	filter_result_t wanted;
	bit failed = 1'b0;
	int idle_cycles = 0;
	int send_idle_pct = 13;
	int recv_idle_pct = 80;

	// expectation typed into a directed row, held with the word
	logic row_typed = 1'b0;
	logic [DATA_W-1:0] row_est = '0;
	logic [F:0] row_gain = '0;

	logic signed [DATA_W-1:0] truth = '0;

	scalar_kalman_filter_top #(
		.FRAC_BITS(F)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.measurement(measurement),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.filtered_estimate(filtered_estimate),
		.kalman_gain(kalman_gain)
	);

	function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
		return '{1'b1, idx, data, 1'b0, '0, '0};
	endfunction

	function automatic stim_row_t meas_row(logic [DATA_W-1:0] z);
		return '{1'b0, '0, z, 1'b0, '0, '0};
	endfunction

	function automatic stim_row_t typed_row(logic [DATA_W-1:0] z, logic [DATA_W-1:0] est,
			logic [F:0] gain);
		return '{1'b0, '0, z, 1'b1, est, gain};
	endfunction

	stim_row_t directed_rows [NUM_DIRECTED] = '{
		// after reset: gain one half, estimate halfway to the sample
		typed_row(32'h0001_0000, 32'h0000_8000, 17'd32768),
		meas_row(32'hFFFF_0000),
		cfg_row(REG_INIT_ESTIMATE, 32'h1234_5678),
		cfg_row(REG_INIT_VARIANCE, 32'd0),
		cfg_row(REG_PROCESS_NOISE, 32'd0),
		cfg_row(REG_MEAS_NOISE, 32'd0),
		// zero denominator holds the estimate
		typed_row(32'h7FFF_FFFF, 32'h1234_5678, 17'd0),
		typed_row(32'h8000_0000, 32'h1234_5678, 17'd0),
		// no R: gain one, estimate jumps to sample, if variance nonzero
		cfg_row(REG_INIT_VARIANCE, 32'h0001_0000),
		typed_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'd65536),
		typed_row(32'h8000_0000, 32'h7FFF_FFFF, 17'd0),
		cfg_row(REG_INIT_VARIANCE, 32'd1),
		typed_row(32'h8000_0000, 32'h8000_0000, 17'd65536),
		// variance sum saturates
		cfg_row(REG_INIT_VARIANCE, 32'hFFFF_FFFF),
		cfg_row(REG_PROCESS_NOISE, 32'hFFFF_FFFF),
		cfg_row(REG_MEAS_NOISE, 32'hFFFF_FFFF),
		meas_row(32'h7FFF_FFFF),
		meas_row(32'h8000_0000),
		meas_row(32'hFFFF_FFFF),
		cfg_row(REG_INIT_ESTIMATE, 32'h8000_0000),
		cfg_row(REG_MEAS_NOISE, 32'd1),
		meas_row(32'h7FFF_FFFF),
		cfg_row(REG_PROCESS_NOISE, 32'd0),
		cfg_row(REG_MEAS_NOISE, 32'h0001_0000),
		meas_row(32'h0000_0000),
		meas_row(32'h0000_8000)
	};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// one filter step on the model, advances its state
	function automatic filter_result_t kalman_update(logic signed [DATA_W-1:0] z);
		logic [63:0] prior_var;
		logic [63:0] denom;
		logic [63:0] gain;
		logic [63:0] post_var;
		longint innov;
		longint correction;
		longint next_est;
		filter_result_t res;
		prior_var = {32'd0, var_model} + {32'd0, q_model};
		if (prior_var > U32_MAX)
			prior_var = U32_MAX;
		denom = prior_var + {32'd0, r_model};
		gain = 64'd0;
		if (denom != 64'd0)
			gain = ((prior_var << F) + (denom >> 1)) / denom;
		if (gain > GAIN_ONE)
			gain = GAIN_ONE;
		innov = longint'(z) - longint'(est_model);
		correction = (longint'(gain) * innov + longint'(HALF_LSB)) >>> F;
		next_est = longint'(est_model) + correction;
		if (next_est > 64'sd2147483647)
			next_est = 64'sd2147483647;
		if (next_est < -64'sd2147483648)
			next_est = -64'sd2147483648;
		post_var = ((GAIN_ONE - gain) * prior_var + HALF_LSB) >> F;
		if (post_var > U32_MAX)
			post_var = U32_MAX;
		est_model = next_est[DATA_W-1:0];
		var_model = post_var[DATA_W-1:0];
		res.est = next_est[DATA_W-1:0];
		res.gain = gain[F:0];
		return res;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_INIT_ESTIMATE: est_model = cfg_data;
					REG_INIT_VARIANCE: var_model = cfg_data;
					REG_PROCESS_NOISE: q_model = cfg_data;
					REG_MEAS_NOISE: r_model = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected word: filtered_estimate %0d kalman_gain %0d",
						filtered_estimate, kalman_gain);
					failed = 1'b1;
				end else begin
					wanted = pending_results.pop_front();
					if (filtered_estimate !== wanted.est) begin
						$error("filtered_estimate expected %0d actual %0d",
							$signed(wanted.est), filtered_estimate);
						failed = 1'b1;
					end
					if (kalman_gain !== wanted.gain) begin
						$error("kalman_gain expected %0d actual %0d", wanted.gain, kalman_gain);
						failed = 1'b1;
					end
				end
			end
			if (in_valid && in_ready) begin
				predicted = kalman_update(measurement);
				if (row_typed) begin
					predicted.est = row_est;
					predicted.gain = row_gain;
				end
				pending_results.push_back(predicted);
			end
			if (cfg_wen || (in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	initial begin : watchdog
		while (idle_cycles < WATCHDOG_LIMIT)
			@(negedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after the accept
	task automatic send_word(logic [DATA_W-1:0] z, logic typed, logic [DATA_W-1:0] est,
			logic [F:0] gain);
		cfg_wen <= 1'b0;
		// sender idles cycle by cycle
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		row_typed = typed;
		row_est = est;
		row_gain = gain;
		in_valid <= 1'b1;
		measurement <= z;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		cfg_wen <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4)
			@(negedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_variance();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(1, 255);
			3: return $urandom_range(32'h0000_1000, 32'h0010_0000);
			4: return $urandom;
			default: return 32'h0001_0000;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_estimate();
		case ($urandom_range(3))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return truth;
			default: return $urandom;
		endcase
	endfunction

	// mostly noisy samples around a slowly drifting level
	function automatic logic [DATA_W-1:0] next_measurement();
		int pick;
		pick = $urandom_range(99);
		if (pick < 5)
			truth = $urandom;
		else
			truth = truth + $urandom_range(0, 4095) - 2048;
		if (pick < 65)
			return truth + $urandom_range(0, 131071) - 65536;
		if (pick < 88)
			return $urandom;
		case ($urandom_range(3))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	task automatic randomize_settings(bit all_regs);
		wait_idle();
		if (all_regs || $urandom_range(1))
			write_reg(REG_INIT_ESTIMATE, pick_estimate());
		if (all_regs || $urandom_range(1))
			write_reg(REG_INIT_VARIANCE, pick_variance());
		if (all_regs || $urandom_range(1))
			write_reg(REG_PROCESS_NOISE, pick_variance());
		if (all_regs || $urandom_range(1))
			write_reg(REG_MEAS_NOISE, pick_variance());
	endtask

	initial begin : stimulus
		int i;
		int phase;
		stim_row_t row;
		repeat (3)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < NUM_DIRECTED; i++) begin
			row = directed_rows[i];
			if (row.is_cfg) begin
				if (i == 0 || !directed_rows[i-1].is_cfg)
					wait_idle();
				write_reg(row.idx, row.data);
			end else begin
				send_word(row.data, row.typed, row.est, row.gain);
			end
		end

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 13;
					recv_idle_pct = 80;
				end
				1: begin
					send_idle_pct = 80;
					recv_idle_pct = 13;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i % RECONFIG_EVERY == 0)
					randomize_settings(i == 0);
				send_word(next_measurement(), 1'b0, '0, '0);
			end
		end

		in_valid <= 1'b0;
		cfg_wen <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (2 * LATENCY)
			@(negedge clk);
		if (!failed)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
